@@ rtl/core/dwgs_pkg.sv @@
// Shared types and constants of the damped wave grid step block.
package dwgs_pkg;

  localparam int DATA_W = 32;
  localparam int CW     = 16;
  localparam int OPW    = 37;
  localparam int MW     = 17;
  localparam int PW     = OPW + MW;
  localparam int DW     = OPW + 16;

  localparam logic [CW-1:0] SPRING_RST = 16'd32768;
  localparam logic [CW-1:0] DAMP_RST   = 16'd13;
  localparam logic [CW-1:0] GAIN_RST   = 16'd49152;
  localparam logic [MW-1:0] ONE_Q16    = 17'h10000;

  typedef enum logic [1:0] {
    REG_SPRING  = 2'd0,
    REG_DAMPING = 2'd1,
    REG_GAIN    = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic           done;
    logic [OPW-1:0] value;
  } arith_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_I_ADDR,
    ST_I_DATA,
    ST_MA_GO,
    ST_MA_WAIT,
    ST_MB_GO,
    ST_MB_WAIT,
    ST_DV_GO,
    ST_DV_WAIT,
    ST_G_ADDR,
    ST_G_DATA,
    ST_G_WAIT,
    ST_E_ADDR,
    ST_E_DATA,
    ST_E_HOLD
  } state_t;

endpackage

@@ rtl/core/dwgs_ram.sv @@
// Generic single write port RAM with one registered read port.
module dwgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/dwgs_arith.sv @@
// Shared bit-serial multiplier and restoring divider of the stencil datapath.
module dwgs_arith (
  input  logic                               clk,
  input  logic                               rst,
  input  dwgs_pkg::arith_req_t               req,
  input  logic signed [dwgs_pkg::OPW-1:0]    x,
  input  logic [dwgs_pkg::MW-1:0]            m,
  output dwgs_pkg::arith_rsp_t               rsp
);
  import dwgs_pkg::*;

  logic                  busy;
  logic                  done;
  arith_op_t             op_q;
  logic [5:0]            cnt;
  logic signed [PW-1:0]  acc;
  logic signed [OPW-1:0] mx;
  logic [MW-1:0]         mm;
  logic                  neg;
  logic [MW-1:0]         rem;
  logic [DW-1:0]         dvd;
  logic [DW-1:0]         quo;
  logic [OPW-1:0]        value;

  logic signed [PW-1:0]  addend;
  logic signed [PW-1:0]  acc_step;
  logic [OPW-1:0]        xmag;
  logic [MW:0]           trial;
  logic [MW:0]           diff;
  logic                  fits;
  logic [DATA_W-1:0]     sat_q;
  logic [OPW-1:0]        final_val;

  always_comb begin
    addend   = mm[MW-1] ? {{MW{mx[OPW-1]}}, mx} : '0;
    acc_step = (acc <<< 1) + addend;
    xmag     = x[OPW-1] ? (~x + OPW'(1)) : x;
    trial    = {rem, dvd[DW-1]};
    diff     = trial - {1'b0, mm};
    fits     = (trial >= {1'b0, mm});
    // The quotient magnitude stays far below the dividend width, so a
    // compare against the 32-bit limits is enough to saturate.
    if (!neg && (quo > DW'(32'h7fffffff))) begin
      sat_q = 32'h7fffffff;
    end else if (neg && (quo > DW'(33'h080000000))) begin
      sat_q = 32'h80000000;
    end else if (neg) begin
      sat_q = ~quo[DATA_W-1:0] + DATA_W'(1);
    end else begin
      sat_q = quo[DATA_W-1:0];
    end
    if (op_q == OP_MUL) begin
      final_val = acc[OPW+15:16];
    end else begin
      final_val = {{(OPW-DATA_W){sat_q[DATA_W-1]}}, sat_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == OP_MUL) ? 6'(MW) : 6'(DW);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 6'd1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_q <= req.op;
      mx   <= x;
      mm   <= m;
      acc  <= '0;
      rem  <= '0;
      quo  <= '0;
      neg  <= x[OPW-1];
      dvd  <= {xmag, 16'h0000};
    end else if (busy) begin
      if (cnt != '0) begin
        if (op_q == OP_MUL) begin
          acc <= acc_step;
          mm  <= {mm[MW-2:0], 1'b0};
        end else begin
          rem <= fits ? diff[MW-1:0] : trial[MW-1:0];
          quo <= {quo[DW-2:0], fits};
          dvd <= {dvd[DW-2:0], 1'b0};
        end
      end else begin
        value <= final_val;
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

@@ rtl/core/damped_wave_grid_step.sv @@
// Top level of the damped wave grid step block.
// After reset the block zeroes its grids and is not ready meanwhile; configuration
// writes are taken at any time. A strike item (tuser high) is taken straight from
// idle and gives no result. A step item runs every interior cell through one
// shared serial multiplier and divider: two multiplies, a division and six grid
// reads a cell. Then 4*MESH_DIM border writes follow, each a gain multiply of a
// neighbour cell, and then every cell is emitted, waiting while the output side
// stalls. The grids live in three rotating RAM banks, so the shift of the grids
// at the end of a step costs nothing.
module damped_wave_grid_step #(
  parameter int MESH_DIM = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] strike_amplitude
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [5:0] cell_row, [11:6] cell_col, [43:12] displacement
  output logic        m_axis_tlast,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);
  import dwgs_pkg::*;

  localparam int CELLS = MESH_DIM * MESH_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MESH_DIM);
  localparam logic [AW-1:0] N_A      = AW'(MESH_DIM);
  localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
  localparam logic [RW-1:0] LAST_RC  = RW'(MESH_DIM - 1);
  localparam logic [RW-1:0] PEN_RC   = RW'(MESH_DIM - 2);
  localparam logic [RW-1:0] CTR_RC   = RW'(MESH_DIM / 2);
  localparam logic [RW-1:0] ONE_RC   = RW'(1);

  state_t state, state_next;

  logic [CW-1:0] spring_coeff, damping_coeff, edge_gain;
  logic [1:0]    p_bank, o_bank, n_bank;
  logic [RW-1:0] row, col, ei;
  logic [2:0]    tap;
  logic [1:0]    ek;
  logic          corner;
  logic [AW-1:0] ecnt;
  logic signed [OPW-1:0] acc, old, pcx;
  logic [DATA_W-1:0] pc;

  logic [5:0]        out_row, out_col;
  logic [DATA_W-1:0] out_disp;
  logic              out_last;
  logic              out_valid;

  arith_req_t            req;
  arith_rsp_t            rsp;
  logic signed [OPW-1:0] ax;
  logic [MW-1:0]         am;

  logic [RW-1:0]     rr, rc, sr, sc, dr, dc;
  logic [AW-1:0]     raddr, waddr;
  logic [DATA_W-1:0] wdata, rsel_data;
  logic [DATA_W-1:0] rd [3];
  logic [1:0]        rsel, wbank;
  logic              wr, clear;
  logic [2:0]        bank_we;
  logic signed [OPW-1:0] rdv;
  logic              last_interior, last_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_coeff  <= SPRING_RST;
      damping_coeff <= DAMP_RST;
      edge_gain     <= GAIN_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SPRING:  spring_coeff  <= wr_data;
        REG_DAMPING: damping_coeff <= wr_data;
        REG_GAIN:    edge_gain     <= wr_data;
        default: ;
      endcase
    end
  end

  // Interior read coordinates: centre, four neighbours, then the older grid.
  always_comb begin
    rr = row;
    rc = col;
    unique case (tap)
      3'd1:    rr = row - ONE_RC;
      3'd2:    rr = row + ONE_RC;
      3'd3:    rc = col - ONE_RC;
      3'd4:    rc = col + ONE_RC;
      default: ;
    endcase
  end

  // Border fill order: per index the top, bottom, left and right edge, then the corners.
  always_comb begin
    if (!corner) begin
      unique case (ek)
        2'd0: begin dr = '0;      dc = ei;      sr = ONE_RC;  sc = ei;      end
        2'd1: begin dr = LAST_RC; dc = ei;      sr = PEN_RC;  sc = ei;      end
        2'd2: begin dr = ei;      dc = '0;      sr = ei;      sc = ONE_RC;  end
        default: begin dr = ei;   dc = LAST_RC; sr = ei;      sc = PEN_RC;  end
      endcase
    end else begin
      unique case (ek)
        2'd0: begin dr = '0;      dc = '0;      sr = ONE_RC;  sc = '0;      end
        2'd1: begin dr = LAST_RC; dc = '0;      sr = PEN_RC;  sc = '0;      end
        2'd2: begin dr = '0;      dc = LAST_RC; sr = '0;      sc = PEN_RC;  end
        default: begin dr = LAST_RC; dc = LAST_RC; sr = LAST_RC; sc = PEN_RC; end
      endcase
    end
  end

  assign last_interior = (row == PEN_RC) && (col == PEN_RC);
  assign last_edge     = corner && (ek == 2'd3);

  always_comb begin
    unique case (rsel)
      2'd0:    rsel_data = rd[0];
      2'd1:    rsel_data = rd[1];
      default: rsel_data = rd[2];
    endcase
  end
  assign rdv = {{(OPW-DATA_W){rsel_data[DATA_W-1]}}, rsel_data};
  assign pcx = {{(OPW-DATA_W){pc[DATA_W-1]}}, pc};

  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.op     = OP_MUL;
    ax         = acc;
    am         = {1'b0, spring_coeff};
    raddr      = ecnt;
    rsel       = n_bank;
    wr         = 1'b0;
    wbank      = n_bank;
    waddr      = ecnt;
    wdata      = rsp.value[DATA_W-1:0];
    clear      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clear = 1'b1;
        wdata = '0;
        if (ecnt == LAST_A) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            wr    = 1'b1;
            wbank = p_bank;
            waddr = AW'(CTR_RC) * N_A + AW'(CTR_RC);
            wdata = s_axis_tdata;
          end else begin
            state_next = ST_I_ADDR;
          end
        end
      end
      ST_I_ADDR, ST_I_DATA: begin
        raddr = AW'(rr) * N_A + AW'(rc);
        rsel  = (tap == 3'd5) ? o_bank : p_bank;
        if (state == ST_I_ADDR) state_next = ST_I_DATA;
        else state_next = (tap == 3'd5) ? ST_MA_GO : ST_I_ADDR;
      end
      ST_MA_GO: begin
        req.start  = 1'b1;
        state_next = ST_MA_WAIT;
      end
      ST_MA_WAIT: if (rsp.done) state_next = ST_MB_GO;
      ST_MB_GO: begin
        req.start  = 1'b1;
        ax         = old;
        am         = ONE_Q16 - {1'b0, damping_coeff};
        state_next = ST_MB_WAIT;
      end
      ST_MB_WAIT: if (rsp.done) state_next = ST_DV_GO;
      ST_DV_GO: begin
        req.start  = 1'b1;
        req.op     = OP_DIV;
        am         = ONE_Q16 + {1'b0, damping_coeff};
        state_next = ST_DV_WAIT;
      end
      ST_DV_WAIT: begin
        waddr = AW'(row) * N_A + AW'(col);
        if (rsp.done) begin
          wr         = 1'b1;
          state_next = last_interior ? ST_G_ADDR : ST_I_ADDR;
        end
      end
      ST_G_ADDR, ST_G_DATA: begin
        raddr = AW'(sr) * N_A + AW'(sc);
        ax    = rdv;
        am    = {1'b0, edge_gain};
        if (state == ST_G_ADDR) begin
          state_next = ST_G_DATA;
        end else begin
          req.start  = 1'b1;
          state_next = ST_G_WAIT;
        end
      end
      ST_G_WAIT: begin
        waddr = AW'(dr) * N_A + AW'(dc);
        if (rsp.done) begin
          wr         = 1'b1;
          state_next = last_edge ? ST_E_ADDR : ST_G_ADDR;
        end
      end
      ST_E_ADDR: state_next = ST_E_DATA;
      ST_E_DATA: state_next = ST_E_HOLD;
      ST_E_HOLD: begin
        if (m_axis_tready) state_next = out_last ? ST_IDLE : ST_E_ADDR;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_bank    <= 2'd0;
      o_bank    <= 2'd1;
      n_bank    <= 2'd2;
      ecnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) ecnt <= (ecnt == LAST_A) ? '0 : ecnt + AW'(1);
      if (state == ST_G_WAIT && rsp.done && last_edge) ecnt <= '0;
      if (state == ST_E_DATA) out_valid <= 1'b1;
      if (state == ST_E_HOLD && m_axis_tready) begin
        out_valid <= 1'b0;
        if (out_last) begin
          p_bank <= n_bank;
          o_bank <= p_bank;
          n_bank <= o_bank;
        end else begin
          ecnt <= ecnt + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        row <= ONE_RC;
        col <= ONE_RC;
        tap <= '0;
      end
      ST_I_DATA: begin
        unique case (tap)
          3'd0: begin
            pc  <= rsel_data;
            acc <= -(rdv <<< 2);
          end
          3'd5:    old <= rdv;
          default: acc <= acc + rdv;
        endcase
        tap <= (tap == 3'd5) ? 3'd0 : tap + 3'd1;
      end
      ST_MA_WAIT: if (rsp.done) acc <= $signed(rsp.value) + (pcx <<< 1);
      ST_MB_WAIT: if (rsp.done) acc <= acc - $signed(rsp.value);
      ST_DV_WAIT: begin
        if (rsp.done) begin
          if (col == PEN_RC) begin
            col <= ONE_RC;
            row <= row + ONE_RC;
          end else begin
            col <= col + ONE_RC;
          end
          ei     <= ONE_RC;
          ek     <= 2'd0;
          corner <= 1'b0;
        end
      end
      ST_G_WAIT: begin
        if (rsp.done) begin
          ek <= ek + 2'd1;
          if (!corner && ek == 2'd3) begin
            if (ei == LAST_RC) corner <= 1'b1;
            else ei <= ei + ONE_RC;
          end
          row <= '0;
          col <= '0;
        end
      end
      ST_E_DATA: begin
        out_row  <= 6'(row);
        out_col  <= 6'(col);
        out_disp <= rsel_data;
        out_last <= (ecnt == LAST_A);
      end
      ST_E_HOLD: begin
        if (m_axis_tready) begin
          if (col == LAST_RC) begin
            col <= '0;
            row <= row + ONE_RC;
          end else begin
            col <= col + ONE_RC;
          end
        end
      end
      default: ;
    endcase
  end

  dwgs_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .x   (ax),
    .m   (am),
    .rsp (rsp)
  );

  for (genvar b = 0; b < 3; b++) begin : g_bank
    assign bank_we[b] = clear || (wr && (wbank == 2'(b)));
    dwgs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CELLS)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rd[b])
    );
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_disp, out_col, out_row};
  assign m_axis_tlast  = out_last;

endmodule
